// ----- hw/rtl/pssf_pkg.sv -----
// Shared types, constants and the Gaussian weight table of the pen stroke smoothing core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pssf_pkg;

	localparam int COORD_W    = 32;
	localparam int PRESS_W    = 16;
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = 6;
	localparam int WGT_W      = 17;
	localparam int WSUM_W     = 23;
	localparam int SUM_W      = 56;
	localparam int CNT_W      = 7;
	localparam int MODE_W     = 3;
	localparam int STR_W      = 5;
	localparam int KIND_W     = 2;
	localparam int CFG_W      = 5;
	localparam int DATA_W     = 2 * COORD_W + PRESS_W;
	localparam int ROM_AW     = STR_W + RING_AW;
	localparam int ROM_DEPTH  = 1 << ROM_AW;

	localparam logic [COORD_W-1:0] COORD_SIGN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SIMPLE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GAUSS  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DIST   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	localparam logic CFG_MODE     = 1'b0;
	localparam logic CFG_STRENGTH = 1'b1;

	typedef struct packed {
		logic [PRESS_W-1:0] p;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} pssf_point_t;

	typedef struct packed {
		logic               start;
		logic               add;
		logic               copy;
		logic               acc_clear;
		logic               acc_issue;
		logic [RING_AW-1:0] age;
		logic               div_start;
		logic               len_start;
		logic               travel_upd;
		logic               drain_dec;
		logic               set_drawn;
		logic               out_load;
		logic               out_sel_avg;
		logic               out_last;
	} pssf_cmd_t;

	typedef struct packed {
		logic               avg;
		logic               dist_mode;
		logic [CNT_W-1:0]   win_len;
		logic [RING_AW-1:0] drain;
		logic               last_drawn;
		logic               div_done;
		logic               len_done;
		logic               draw;
		logic               out_free;
	} pssf_sts_t;

	typedef logic [WGT_W-1:0] gauss_rom_t [ROM_DEPTH];

	function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [WGT_W-1:0] gauss_weight(input logic [63:0] k, input logic [63:0] n);
		logic [63:0] u;
		logic [63:0] term;
		logic [63:0] e;
		u    = cdiv((k * k) << 30, 64'd4 * n * n);
		term = 64'd1 << 30;
		e    = 64'd1 << 30;
		for (int j = 1; j <= 10; j++) begin
			term = cdiv((term * u) >> 30, 64'(j));
			if (j[0])
				e = e - term;
			else
				e = e + term;
		end
		for (int r = 0; r < 3; r++)
			e = (e * e + (64'd1 << 29)) >> 30;
		e = (e + (64'd1 << 13)) >> 14;
		return e[WGT_W-1:0];
	endfunction

	function automatic gauss_rom_t gauss_rom_build();
		gauss_rom_t rom;
		logic [63:0] n;
		for (int s = 0; s < (1 << STR_W); s++) begin
			n = 64'(2 + 2 * s);
			for (int k = 0; k < RING_DEPTH; k++) begin
				if (64'(k) < n)
					rom[s * RING_DEPTH + k] = gauss_weight(64'(k), n);
				else
					rom[s * RING_DEPTH + k] = '0;
			end
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pssf_div.sv -----
// Restoring divider, one quotient bit per cycle, for the weighted averages.
// Depends on pssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pssf_div import pssf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [WSUM_W-1:0]  divisor,
	output logic [COORD_W-1:0] quotient,
	output logic               done
);

	logic [SUM_W-1:0]  dq_q;
	logic [WSUM_W-1:0] rem_q;
	logic [WSUM_W-1:0] dv_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WSUM_W:0]   trial;
	logic [WSUM_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign ge    = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

	assign quotient = dq_q[COORD_W-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pssf_len.sv -----
// Step length unit: squares the coordinate deltas and takes an iterative integer square root.
// Depends on pssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pssf_len import pssf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] ax,
	input  logic [COORD_W-1:0] bx,
	input  logic [COORD_W-1:0] ay,
	input  logic [COORD_W-1:0] by,
	output logic [COORD_W-1:0] len,
	output logic               done
);

	logic [COORD_W-1:0]   dx_q;
	logic [COORD_W-1:0]   dy_q;
	logic [2*COORD_W-1:0] xx_q;
	logic [2*COORD_W-1:0] yy_q;
	logic [2*COORD_W-1:0] rem_q;
	logic [2*COORD_W-1:0] res_q;
	logic [2*COORD_W-1:0] bit_q;
	logic [2*COORD_W:0]   sq_sum;
	logic [2*COORD_W-1:0] tst;
	logic                 sat_q;
	logic [5:0]           step_q;
	logic                 busy_q;
	logic                 done_q;

	assign sq_sum = {1'b0, xx_q} + {1'b0, yy_q};
	assign tst    = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 6'd1;
			if (step_q == 6'(COORD_W + 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dx_q <= (ax >= bx) ? ax - bx : bx - ax;
			dy_q <= (ay >= by) ? ay - by : by - ay;
		end else if (busy_q) begin
			if (step_q == 6'd0) begin
				xx_q <= (2*COORD_W)'(dx_q) * (2*COORD_W)'(dx_q);
				yy_q <= (2*COORD_W)'(dy_q) * (2*COORD_W)'(dy_q);
			end else if (step_q == 6'd1) begin
				rem_q <= sq_sum[2*COORD_W-1:0];
				sat_q <= sq_sum[2*COORD_W];
				res_q <= '0;
				bit_q <= {2'b01, {(2*COORD_W-2){1'b0}}};
			end else begin
				if (rem_q >= tst) begin
					rem_q <= rem_q - tst;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign len  = sat_q ? '1 : res_q[COORD_W-1:0];
	assign done = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pssf_datapath.sv -----
// Datapath: configuration, point ring, weighted sums, dividers, travel and output register.
// Depends on pssf_pkg, pssf_div and pssf_len.
`timescale 1ns / 1ps
`default_nettype none

module pssf_datapath import pssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [DATA_W-1:0] in_data,
	input  pssf_cmd_t         cmd,
	output pssf_sts_t         sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data,
	output logic              out_last
);

	localparam gauss_rom_t GAUSS_ROM = gauss_rom_build();

	logic [MODE_W-1:0]  mode_q;
	logic [STR_W-1:0]   strength_q;
	pssf_point_t        ring_q [RING_DEPTH];
	logic [RING_AW-1:0] wptr_q;
	pssf_point_t        lp_q;
	logic [COORD_W-1:0] prev_x_q;
	logic [COORD_W-1:0] prev_y_q;
	logic [RING_AW-1:0] drain_q;
	logic [COORD_W-1:0] travel_q;
	logic               drawn_q;

	pssf_point_t        in_pt;
	pssf_point_t        wdata;
	logic [RING_AW-1:0] waddr;
	logic [RING_AW-1:0] raddr;
	logic               wr_en;
	logic [CNT_W-1:0]   win_len;

	pssf_point_t        rd_s1;
	logic [WGT_W-1:0]   rom_s1;
	logic [WGT_W-1:0]   lin_s1;
	logic               v_s1;
	logic [WGT_W-1:0]   w_sel;
	logic [COORD_W+WGT_W-1:0] px_s2;
	logic [COORD_W+WGT_W-1:0] py_s2;
	logic [PRESS_W+WGT_W-1:0] pp_s2;
	logic [WGT_W-1:0]   w_s2;
	logic               v_s2;
	logic [SUM_W-1:0]   sx_q;
	logic [SUM_W-1:0]   sy_q;
	logic [SUM_W-1:0]   sp_q;
	logic [WSUM_W-1:0]  ws_q;
	logic [SUM_W-1:0]   half_w;

	logic [COORD_W-1:0] qx;
	logic [COORD_W-1:0] qy;
	logic [COORD_W-1:0] qp;
	logic               dx_done;
	logic               dy_done;
	logic               dp_done;

	logic [COORD_W-1:0] len;
	logic               len_done;
	logic [COORD_W:0]   acc_sum;
	logic [COORD_W-1:0] acc_sat;
	logic [COORD_W-1:0] thresh;
	logic [STR_W:0]     dist_min;
	logic               draw;

	logic               ovalid_q;
	logic [DATA_W-1:0]  odata_q;
	logic               olast_q;
	logic               out_free;

	assign in_pt.x = in_data[COORD_W-1:0] ^ COORD_SIGN;
	assign in_pt.y = in_data[2*COORD_W-1:COORD_W] ^ COORD_SIGN;
	assign in_pt.p = in_data[DATA_W-1:2*COORD_W];

	assign win_len = {1'b0, strength_q, 1'b0} + 7'd2;
	assign wr_en   = cmd.start | cmd.add | cmd.copy;
	assign waddr   = cmd.start ? '0 : wptr_q;
	assign wdata   = (cmd.start | cmd.add) ? in_pt : lp_q;
	assign raddr   = wptr_q - 6'd1 - cmd.age;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NONE;
			strength_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				CFG_STRENGTH: strength_q <= cfg_data[STR_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ring_q[waddr] <= wdata;
		rd_s1  <= ring_q[raddr];
		rom_s1 <= GAUSS_ROM[{strength_q, cmd.age}];
		lin_s1 <= WGT_W'(win_len - {1'b0, cmd.age});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			drain_q  <= '0;
			travel_q <= '0;
			drawn_q  <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= cmd.acc_issue;
			v_s2 <= v_s1;
			if (cmd.start)
				wptr_q <= 6'd1;
			else if (cmd.add | cmd.copy)
				wptr_q <= wptr_q + 6'd1;
			if (cmd.start)
				drain_q <= sts.avg ? {strength_q, 1'b1} : '0;
			else if (cmd.drain_dec)
				drain_q <= drain_q - 6'd1;
			if (cmd.start) begin
				travel_q <= '0;
				drawn_q  <= 1'b0;
			end else if (cmd.travel_upd) begin
				travel_q <= draw ? '0 : acc_sat;
				drawn_q  <= draw;
			end else if (cmd.set_drawn) begin
				drawn_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start | cmd.add) begin
			lp_q     <= in_pt;
			prev_x_q <= lp_q.x;
			prev_y_q <= lp_q.y;
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_SIMPLE: w_sel = WGT_W'(1);
			MODE_LINEAR: w_sel = lin_s1;
			default:     w_sel = rom_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		px_s2 <= (COORD_W+WGT_W)'(rd_s1.x) * (COORD_W+WGT_W)'(w_sel);
		py_s2 <= (COORD_W+WGT_W)'(rd_s1.y) * (COORD_W+WGT_W)'(w_sel);
		pp_s2 <= (PRESS_W+WGT_W)'(rd_s1.p) * (PRESS_W+WGT_W)'(w_sel);
		w_s2  <= w_sel;
		if (cmd.acc_clear) begin
			sx_q <= '0;
			sy_q <= '0;
			sp_q <= '0;
			ws_q <= '0;
		end else if (v_s2) begin
			sx_q <= sx_q + SUM_W'(px_s2);
			sy_q <= sy_q + SUM_W'(py_s2);
			sp_q <= sp_q + SUM_W'(pp_s2);
			ws_q <= ws_q + WSUM_W'(w_s2);
		end
	end

	assign half_w = SUM_W'(ws_q >> 1);

	pssf_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sx_q + half_w),
		.divisor  (ws_q),
		.quotient (qx),
		.done     (dx_done)
	);

	pssf_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sy_q + half_w),
		.divisor  (ws_q),
		.quotient (qy),
		.done     (dy_done)
	);

	pssf_div u_div_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sp_q + half_w),
		.divisor  (ws_q),
		.quotient (qp),
		.done     (dp_done)
	);

	pssf_len u_len (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.len_start),
		.ax     (lp_q.x),
		.bx     (prev_x_q),
		.ay     (lp_q.y),
		.by     (prev_y_q),
		.len    (len),
		.done   (len_done)
	);

	assign acc_sum  = {1'b0, travel_q} + {1'b0, len};
	assign acc_sat  = acc_sum[COORD_W] ? '1 : acc_sum[COORD_W-1:0];
	assign dist_min = {1'b0, strength_q} + 6'd2;
	assign thresh   = COORD_W'({dist_min, 16'h0000});
	assign draw     = acc_sat >= thresh;

	assign out_free = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.out_load)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			olast_q <= cmd.out_last;
			if (cmd.out_sel_avg)
				odata_q <= {qp[PRESS_W-1:0], qy ^ COORD_SIGN, qx ^ COORD_SIGN};
			else
				odata_q <= {lp_q.p, lp_q.y ^ COORD_SIGN, lp_q.x ^ COORD_SIGN};
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign out_last  = olast_q;

	assign sts.avg        = (mode_q == MODE_SIMPLE) || (mode_q == MODE_LINEAR) ||
	                        (mode_q == MODE_GAUSS);
	assign sts.dist_mode  = mode_q == MODE_DIST;
	assign sts.win_len    = win_len;
	assign sts.drain      = drain_q;
	assign sts.last_drawn = drawn_q;
	assign sts.div_done   = dx_done & dy_done & dp_done;
	assign sts.len_done   = len_done;
	assign sts.draw       = draw;
	assign sts.out_free   = out_free;

endmodule

`default_nettype wire

// ----- hw/rtl/pssf_ctrl.sv -----
// Controller state machine: sequences ring fills, weighted sums, divisions, travel and results.
// Depends on pssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pssf_ctrl import pssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              in_ready,
	output pssf_cmd_t         cmd,
	input  pssf_sts_t         sts
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_FILL  = 8'b0000_0010,
		ST_ACC   = 8'b0000_0100,
		ST_DIVW  = 8'b0000_1000,
		ST_EMIT  = 8'b0001_0000,
		ST_DRAIN = 8'b0010_0000,
		ST_DIST  = 8'b0100_0000,
		ST_LENW  = 8'b1000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             sel_avg_q, sel_avg_d;
	logic             last_q, last_d;
	logic             dec_q, dec_d;
	logic             setd_q, setd_d;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		sel_avg_d = sel_avg_q;
		last_d    = last_q;
		dec_d     = dec_q;
		setd_d    = setd_q;
		cmd       = '0;
		cmd.age   = cnt_q[RING_AW-1:0];
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				sel_avg_d = 1'b0;
				last_d    = 1'b1;
				dec_d     = 1'b0;
				setd_d    = 1'b0;
				if (in_valid) begin
					unique case (kind)
						KIND_START: begin
							cmd.start = 1'b1;
							cnt_d     = 7'd1;
							if (sts.avg)
								state_d = ST_FILL;
						end
						KIND_ADD: begin
							cmd.add = 1'b1;
							if (sts.avg) begin
								cmd.acc_clear = 1'b1;
								cnt_d         = '0;
								sel_avg_d     = 1'b1;
								state_d       = ST_ACC;
							end else if (sts.dist_mode) begin
								state_d = ST_DIST;
							end else begin
								state_d = ST_EMIT;
							end
						end
						KIND_FINISH: begin
							if (sts.avg) begin
								state_d = ST_DRAIN;
							end else if (sts.dist_mode && !sts.last_drawn) begin
								setd_d  = 1'b1;
								state_d = ST_EMIT;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				cmd.copy = 1'b1;
				cnt_d    = cnt_q + 7'd1;
				if (cnt_q == 7'(sts.win_len - 7'd1))
					state_d = ST_IDLE;
			end
			ST_ACC: begin
				cmd.acc_issue = cnt_q < sts.win_len;
				cnt_d         = cnt_q + 7'd1;
				if (cnt_q == 7'(sts.win_len + 7'd2)) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIVW;
				end
			end
			ST_DIVW: begin
				if (sts.div_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel_avg = sel_avg_q;
					cmd.out_last    = last_q;
					cmd.drain_dec   = dec_q;
					cmd.set_drawn   = setd_q;
					state_d         = dec_q ? ST_DRAIN : ST_IDLE;
				end
			end
			ST_DRAIN: begin
				dec_d = 1'b1;
				if (sts.drain == '0) begin
					state_d = ST_IDLE;
				end else if (sts.drain == 6'd1) begin
					sel_avg_d = 1'b0;
					last_d    = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					cmd.copy      = 1'b1;
					cmd.acc_clear = 1'b1;
					cnt_d         = '0;
					sel_avg_d     = 1'b1;
					last_d        = 1'b0;
					state_d       = ST_ACC;
				end
			end
			ST_DIST: begin
				cmd.len_start = 1'b1;
				state_d       = ST_LENW;
			end
			ST_LENW: begin
				if (sts.len_done) begin
					cmd.travel_upd = 1'b1;
					state_d        = sts.draw ? ST_EMIT : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sel_avg_q <= 1'b0;
			last_q    <= 1'b0;
			dec_q     <= 1'b0;
			setd_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			sel_avg_q <= sel_avg_d;
			last_q    <= last_d;
			dec_q     <= dec_d;
			setd_q    <= setd_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register occupied");

	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider done flag not cleared on start");

	a_copy_avg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy |-> sts.avg)
		else $error("ring copy outside averaging mode");

	a_drain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_dec |-> sts.drain != '0)
		else $error("drain count decremented past zero");

endmodule

`default_nettype wire

// ----- hw/rtl/pen_stroke_smoothing_filter_core.sv -----
// Pen stroke smoothing core top level: controller, datapath and stream/config ports.
// Start stores the first point; averaging modes copy it into n-1 more slots (n = 2+2*strength).
// Averaged point: n reads through a 3-stage multiply-accumulate, a bit-serial divide of the
// 56-bit sums, then a load of the output register; a distance step uses the length unit.
// One request at a time; a finish in averaging modes emits up to 63 results in sequence.
// Reset (arst_n low) clears control, counters and configuration; ring contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module pen_stroke_smoothing_filter_core import pssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // x_in, y_in, pressure_in
	input  logic [KIND_W-1:0] s_axis_tuser,  // kind
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // x_out, y_out, pressure_out
	output logic              m_axis_tlast
);

	pssf_cmd_t cmd;
	pssf_sts_t sts;

	pssf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.kind     (s_axis_tuser),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pssf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire
